// ===== design/aepq_pkg.sv =====
// Package with sizes, codes and types shared by the active/expired ready queue.
package aepq_pkg;

  localparam int NUM_LEVELS  = 4;
  localparam int QUEUE_DEPTH = 16;

  localparam int NUM_QUEUES = 2 * NUM_LEVELS;
  localparam int NUM_SLOTS  = NUM_QUEUES * QUEUE_DEPTH;

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int Q_W    = $clog2(NUM_QUEUES);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_SLOTS);

  localparam int TAG_W   = 8;
  localparam int TIME_W  = 32;
  localparam int ENTRY_W = TAG_W + TIME_W;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_GET = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef logic [CNT_W-1:0] fill_t;
  typedef logic [PTR_W-1:0] head_t;

endpackage

// ===== design/aepq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module aepq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/active_expired_priority_queue_top.sv =====
// Active/expired two-bank ready queue with one FIFO per priority level and bank.
// The sequencer takes one item at a time: an add passes IDLE and EXEC, a get
// passes IDLE, EXEC and READ, where it pays for the registered read of the
// shared entry RAM. A stalled result holds the sequencer.
// Reset clears all fill counts, head pointers and the active bank select; the
// entry RAM is not cleared, since only written slots are ever read.
module active_expired_priority_queue_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [7:0]            process_tag_i,
  input  logic signed [4:0]     dynamic_level_i,
  input  logic [4:0]            static_level_i,
  input  logic [31:0]           now_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [7:0]            out_tag_o,
  output logic [3:0]            out_level_o,
  output logic                  to_expired_o,
  output logic                  banks_swapped_o,
  output logic [31:0]           wait_increment_o
);
  import aepq_pkg::*;

  // Sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0] state_q, state_d;

  // Captured command
  logic              cmd_q;
  logic [TAG_W-1:0]  tag_q;
  logic signed [4:0] dyn_q;
  logic [4:0]        stat_q;
  logic [TIME_W-1:0] now_q;

  // Queue bookkeeping, one entry per (bank, level)
  fill_t fill_q [NUM_QUEUES];
  fill_t fill_d [NUM_QUEUES];
  head_t head_q [NUM_QUEUES];
  head_t head_d [NUM_QUEUES];
  logic  active_q, active_d;

  // Get result held across the RAM read
  logic             get_empty_q;
  logic             get_swap_q;
  logic [LVL_W-1:0] get_lvl_q;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q;
  logic [TAG_W-1:0]  otag_q;
  logic [3:0]        olvl_q;
  logic              oexp_q;
  logic              oswap_q;
  logic [TIME_W-1:0] owait_q;
  logic              out_load;
  logic              out_free;

  // Shared entry RAM
  logic               ram_we;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic in_accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Add: pick bank and level. Quantum expired sends the item to the expired
  // bank at static minus one; other negative levels clamp to level 0; any
  // level past the top saturates.
  // ---------------------------------------------------------------------------
  logic             dyn_expired;
  logic [4:0]       lvl_raw;
  logic [4:0]       lvl_sat;
  logic [LVL_W-1:0] add_lvl;
  logic             add_bank;
  logic [Q_W-1:0]   add_q;
  logic             add_full;
  logic [CNT_W:0]   slot_sum;
  logic [PTR_W-1:0] add_slot;

  always_comb begin
    dyn_expired = (dyn_q == -5'sd1);
    if (dyn_expired) begin
      lvl_raw = (stat_q == 5'd0) ? 5'd0 : stat_q - 5'd1;
    end else begin
      lvl_raw = dyn_q[4] ? 5'd0 : 5'(unsigned'(dyn_q));
    end
    lvl_sat  = (lvl_raw >= 5'(NUM_LEVELS)) ? 5'(NUM_LEVELS - 1) : lvl_raw;
    add_lvl  = LVL_W'(lvl_sat);
    add_bank = dyn_expired ? ~active_q : active_q;
    add_q    = Q_W'(add_bank) * Q_W'(NUM_LEVELS) + Q_W'(add_lvl);
    add_full = (fill_q[add_q] >= CNT_W'(QUEUE_DEPTH));
    // Tail slot wraps once at most: head stays below the depth, count at most equals it.
    slot_sum = (CNT_W + 1)'(head_q[add_q]) + (CNT_W + 1)'(fill_q[add_q]);
    if (slot_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      add_slot = PTR_W'(slot_sum - (CNT_W + 1)'(QUEUE_DEPTH));
    end else begin
      add_slot = PTR_W'(slot_sum);
    end
  end

  // ---------------------------------------------------------------------------
  // Get: find the highest non-empty level of each physical bank, then pick
  // the active one, or swap banks when the active bank is drained.
  // ---------------------------------------------------------------------------
  logic [NUM_LEVELS-1:0] ne0, ne1, ne_act, ne_exp;
  logic [LVL_W-1:0]      top_act, top_exp;
  logic                  act_any, exp_any;
  logic                  get_bank;
  logic [LVL_W-1:0]      get_lvl;
  logic [Q_W-1:0]        get_q;
  logic                  get_empty;

  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      ne0[l] = (fill_q[l] != '0);
      ne1[l] = (fill_q[NUM_LEVELS + l] != '0);
    end
    ne_act  = active_q ? ne1 : ne0;
    ne_exp  = active_q ? ne0 : ne1;
    top_act = '0;
    top_exp = '0;
    // Ascending scan: the last set flag wins, which is the highest level.
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (ne_act[l]) top_act = LVL_W'(l);
      if (ne_exp[l]) top_exp = LVL_W'(l);
    end
    act_any   = |ne_act;
    exp_any   = |ne_exp;
    get_bank  = act_any ? active_q : ~active_q;
    get_lvl   = act_any ? top_act : top_exp;
    get_empty = !act_any && !exp_any;
    get_q     = Q_W'(get_bank) * Q_W'(NUM_LEVELS) + Q_W'(get_lvl);
  end

  assign ram_waddr = ADDR_W'(add_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(add_slot);
  assign ram_raddr = ADDR_W'(get_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[get_q]);

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE takes an item, EXEC updates bookkeeping (and finishes an
  // add), READ forms the get result from the registered RAM data.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    fill_d   = fill_q;
    head_d   = head_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_q == CMD_ADD) begin
          // Hold until the output register has room.
          if (out_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
            if (!add_full) begin
              ram_we         = 1'b1;
              fill_d[add_q]  = fill_q[add_q] + CNT_W'(1);
            end
          end
        end else begin
          state_d = ST_READ;
          if (!act_any) begin
            active_d = ~active_q;
          end
          if (!get_empty) begin
            ram_re = 1'b1;
            fill_d[get_q] = fill_q[get_q] - CNT_W'(1);
            if (head_q[get_q] == PTR_W'(QUEUE_DEPTH - 1)) begin
              head_d[get_q] = '0;
            end else begin
              head_d[get_q] = head_q[get_q] + PTR_W'(1);
            end
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        fill_q[i] <= '0;
        head_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
    end
  end

  // Payload registers: capture on accept, record get outcome, load results.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= command_i;
      tag_q  <= process_tag_i;
      dyn_q  <= dynamic_level_i;
      stat_q <= static_level_i;
      now_q  <= now_i;
    end
    if (state_q == ST_EXEC && cmd_q == CMD_GET) begin
      get_empty_q <= get_empty;
      get_swap_q  <= !act_any;
      get_lvl_q   <= get_lvl;
    end
    if (out_load) begin
      if (state_q == ST_EXEC) begin
        status_q <= add_full ? STATUS_FULL : STATUS_OK;
        otag_q   <= '0;
        olvl_q   <= 4'(add_lvl);
        oexp_q   <= dyn_expired;
        oswap_q  <= 1'b0;
        owait_q  <= '0;
      end else begin
        status_q <= get_empty_q ? STATUS_EMPTY : STATUS_OK;
        otag_q   <= get_empty_q ? '0 : ram_rdata[ENTRY_W-1 -: TAG_W];
        olvl_q   <= get_empty_q ? 4'd0 : 4'(get_lvl_q);
        oexp_q   <= 1'b0;
        oswap_q  <= get_swap_q;
        owait_q  <= get_empty_q ? '0 : now_q - ram_rdata[TIME_W-1:0];
      end
    end
  end

  aepq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({tag_q, now_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign out_tag_o        = otag_q;
  assign out_level_o      = olvl_q;
  assign to_expired_o     = oexp_q;
  assign banks_swapped_o  = oswap_q;
  assign wait_increment_o = owait_q;

  // A new result appears only out of the add step or the read step.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_READ))
    else $error("result loaded outside of EXEC/READ");

  // The read step is entered from a get in the execute step, or held while stalled.
  a_read_after_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> ($past(state_q) == ST_READ ||
                              ($past(state_q) == ST_EXEC && $past(cmd_q) == CMD_GET)))
    else $error("READ entered without a get");

  // A dropped add never carries get fields.
  a_full_is_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == STATUS_FULL) |-> (!oswap_q && otag_q == '0 && owait_q == '0))
    else $error("full status with get fields set");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the two-bank ready queue, with its own scheduler model.
module tb_top;
  import aepq_pkg::*;

  // Dynamic level that marks an expired quantum.
  localparam logic signed [4:0] DYN_EXPIRED = -5'sd1;

  localparam int RANDOM_ITEMS = 1700;
  // Start the long receiver hold-off after this many random items.
  localparam int HOLD_AT_ITEM = 400;
  localparam int HOLD_CYCLES  = 400;
  // Timeout bound, set far above what a correct run needs.
  localparam int CYCLE_LIMIT  = 1000000;
  // Extra cycles to wait at the end for stray results.
  localparam int DRAIN_CYCLES = 8;
  // Room for every expected result of the run.
  localparam int EXPECT_DEPTH = 4096;

  // One result item, in port order.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  tag;
    logic [3:0]  level;
    logic        to_exp;
    logic        swapped;
    logic [31:0] wait_inc;
  } sched_result_t;

  // One row of the directed stimulus. A row repeats reps times, with tag and time
  // stamp advancing by one per repeat. Rows with typed set carry their result.
  typedef struct packed {
    logic               cmd;
    logic [7:0]         tag;
    logic signed [4:0]  dyn;
    logic [4:0]         stat;
    logic [31:0]        now;
    logic [7:0]         reps;
    logic               typed;
    sched_result_t      want;
  } stim_row_t;

  localparam sched_result_t FROM_MODEL = '0;
  localparam int NUM_ROWS = 14;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               command_i;
  logic [7:0]         process_tag_i;
  logic signed [4:0]  dynamic_level_i;
  logic [4:0]         static_level_i;
  logic [31:0]        now_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic [7:0]         out_tag_o;
  logic [3:0]         out_level_o;
  logic               to_expired_o;
  logic               banks_swapped_o;
  logic [31:0]        wait_increment_o;

  active_expired_priority_queue_top i_dut (.*);

  always #1 clk_i = ~clk_i;

  // Scheduler model state: per physical bank and level one FIFO of tag and time.
  logic [7:0]  slot_tag  [NUM_QUEUES][QUEUE_DEPTH];
  logic [31:0] slot_time [NUM_QUEUES][QUEUE_DEPTH];
  int          q_head [NUM_QUEUES];
  int          q_fill [NUM_QUEUES];
  logic        act_bank;

  // Expected results in acceptance order, with write and read counts.
  sched_result_t expect_mem [EXPECT_DEPTH];
  int            expect_wr = 0;
  int            expect_rd = 0;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  bit            hold_request = 1'b0;

  // Directed stimulus. Bank 0 is active after reset.
  stim_row_t dir_rows [NUM_ROWS] = '{
    // get with both banks empty: swap anyway, report nothing to run
    '{CMD_GET, 8'd0,   5'sd0,   5'd0,  32'd5,        8'd1, 1'b1,
      '{STATUS_EMPTY, 8'd0, 4'd0, 1'b0, 1'b1, 32'd0}},
    // dynamic level above the top level saturates; time close to wrap
    '{CMD_ADD, 8'hFF,  5'sd15,  5'd0,  32'hFFFF_FFF0, 8'd1, 1'b1,
      '{STATUS_OK, 8'd0, 4'd3, 1'b0, 1'b0, 32'd0}},
    // expired quantum with static level zero lands on level zero
    '{CMD_ADD, 8'h00,  DYN_EXPIRED, 5'd0,  32'd0,    8'd1, 1'b1,
      '{STATUS_OK, 8'd0, 4'd0, 1'b1, 1'b0, 32'd0}},
    // expired quantum with a static level past the top saturates
    '{CMD_ADD, 8'h5A,  DYN_EXPIRED, 5'd16, 32'd100,  8'd1, 1'b1,
      '{STATUS_OK, 8'd0, 4'd3, 1'b1, 1'b0, 32'd0}},
    // most negative dynamic level goes to level zero of the active bank
    '{CMD_ADD, 8'hA5,  5'b10000, 5'd31, 32'h1234_5678, 8'd1, 1'b1,
      '{STATUS_OK, 8'd0, 4'd0, 1'b0, 1'b0, 32'd0}},
    '{CMD_ADD, 8'h01,  -5'sd2,  5'd1,  32'd7,        8'd1, 1'b1,
      '{STATUS_OK, 8'd0, 4'd0, 1'b0, 1'b0, 32'd0}},
    '{CMD_ADD, 8'h02,  5'sd1,   5'd1,  32'd8,        8'd1, 1'b1,
      '{STATUS_OK, 8'd0, 4'd1, 1'b0, 1'b0, 32'd0}},
    '{CMD_ADD, 8'h03,  DYN_EXPIRED, 5'd1,  32'd9,    8'd1, 1'b1,
      '{STATUS_OK, 8'd0, 4'd0, 1'b1, 1'b0, 32'd0}},
    '{CMD_ADD, 8'h04,  DYN_EXPIRED, 5'd31, 32'd10,   8'd1, 1'b1,
      '{STATUS_OK, 8'd0, 4'd3, 1'b1, 1'b0, 32'd0}},
    // serve the top level; the wait crosses the time wrap
    '{CMD_GET, 8'd0,   5'sd0,   5'd0,  32'h0000_000F, 8'd1, 1'b1,
      '{STATUS_OK, 8'hFF, 4'd3, 1'b0, 1'b0, 32'h0000_001F}},
    // drain the active bank and fall through a swap
    '{CMD_GET, 8'd0,   5'sd0,   5'd0,  32'h2000_0000, 8'd4, 1'b0, FROM_MODEL},
    // fill one level FIFO to the brim, then one more is dropped
    '{CMD_ADD, 8'h70,  5'sd2,   5'd3,  32'h0000_0040, 8'd16, 1'b0, FROM_MODEL},
    '{CMD_ADD, 8'hEE,  5'sd2,   5'd3,  32'h0000_0050, 8'd1, 1'b1,
      '{STATUS_FULL, 8'd0, 4'd2, 1'b0, 1'b0, 32'd0}},
    '{CMD_GET, 8'd0,   5'sd0,   5'd0,  32'hFFFF_FFFF, 8'd3, 1'b0, FROM_MODEL}
  };

  // Highest non-empty level of a physical bank, or -1 if the bank is empty.
  function automatic int top_level(logic bank);
    int lvl;
    for (lvl = NUM_LEVELS - 1; lvl >= 0; lvl--) begin
      if (q_fill[int'(bank) * NUM_LEVELS + lvl] != 0) return lvl;
    end
    return -1;
  endfunction

  // Apply one command to the model state and return the result it produces.
  function automatic sched_result_t schedule_op(logic cmd, logic [7:0] tag,
                                                logic signed [4:0] dyn,
                                                logic [4:0] stat, logic [31:0] now);
    sched_result_t res;
    int   lvl;
    int   q;
    int   slot;
    logic bank;
    res = '0;
    if (cmd == CMD_ADD) begin
      if (dyn == DYN_EXPIRED) begin
        lvl = (stat == 5'd0) ? 0 : int'(stat) - 1;
        bank = ~act_bank;
        res.to_exp = 1'b1;
      end else begin
        lvl = (dyn < 0) ? 0 : int'(dyn);
        bank = act_bank;
      end
      if (lvl >= NUM_LEVELS) lvl = NUM_LEVELS - 1;
      res.level = 4'(lvl);
      q = int'(bank) * NUM_LEVELS + lvl;
      if (q_fill[q] >= QUEUE_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        slot = (q_head[q] + q_fill[q]) % QUEUE_DEPTH;
        slot_tag[q][slot] = tag;
        slot_time[q][slot] = now;
        q_fill[q]++;
      end
    end else begin
      lvl = top_level(act_bank);
      if (lvl < 0) begin
        act_bank = ~act_bank;
        res.swapped = 1'b1;
        lvl = top_level(act_bank);
      end
      if (lvl < 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        q = int'(act_bank) * NUM_LEVELS + lvl;
        res.tag = slot_tag[q][q_head[q]];
        res.level = 4'(lvl);
        res.wait_inc = now - slot_time[q][q_head[q]];
        q_head[q] = (q_head[q] + 1) % QUEUE_DEPTH;
        q_fill[q]--;
      end
    end
    return res;
  endfunction

  // Idle length: mostly none or short, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at cycle %0d", what, got, want,
             cycle_count);
    mismatch_count++;
  endtask

  // Offer one item, hold it until accepted, then queue its expected result.
  // A typed row queues its typed result; the model still advances its state.
  task automatic offer_item(logic cmd, logic [7:0] tag, logic signed [4:0] dyn,
                            logic [4:0] stat, logic [31:0] now,
                            logic typed, sched_result_t want);
    sched_result_t res;
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    process_tag_i   <= tag;
    dynamic_level_i <= dyn;
    static_level_i  <= stat;
    now_i           <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = schedule_op(cmd, tag, dyn, stat, now);
    expect_mem[expect_wr % EXPECT_DEPTH] = typed ? want : res;
    expect_wr++;
  endtask

  // Drop valid for a gap before the next item; with n of zero the next item follows back to back.
  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top failed");
      $finish;
    end
  end

  // Compare each accepted result item with the oldest expectation, field by field.
  always @(posedge clk_i) begin
    sched_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expect_wr == expect_rd) begin
        report_mismatch("result with nothing pending", {30'd0, status_o}, 32'd0);
      end else begin
        exp_res = expect_mem[expect_rd % EXPECT_DEPTH];
        expect_rd++;
        if (status_o !== exp_res.status)
          report_mismatch("status", 32'(status_o), 32'(exp_res.status));
        if (out_tag_o !== exp_res.tag)
          report_mismatch("out_tag", 32'(out_tag_o), 32'(exp_res.tag));
        if (out_level_o !== exp_res.level)
          report_mismatch("out_level", 32'(out_level_o), 32'(exp_res.level));
        if (to_expired_o !== exp_res.to_exp)
          report_mismatch("to_expired", 32'(to_expired_o), 32'(exp_res.to_exp));
        if (banks_swapped_o !== exp_res.swapped)
          report_mismatch("banks_swapped", 32'(banks_swapped_o), 32'(exp_res.swapped));
        if (wait_increment_o !== exp_res.wait_inc)
          report_mismatch("wait_increment", wait_increment_o, exp_res.wait_inc);
      end
    end
  end

  // Receiver: alternate ready runs with stalls of random length. Honor one long
  // hold-off on request so the block backs up and stalls its input.
  initial begin
    int run;
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        for (hold = 0; hold < HOLD_CYCLES; hold++) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 30);
      repeat (run) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat (gap_len()) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
    end
  end

  // Sender: reset, directed rows, then random phases, then drain and judge.
  initial begin
    int          i;
    int          rep;
    int          phase_left;
    int          add_pct;
    bit          quiet;
    logic        cmd;
    logic signed [4:0] dyn;
    logic [4:0]  stat;
    logic [31:0] clock_now;

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    command_i       = CMD_ADD;
    process_tag_i   = '0;
    dynamic_level_i = '0;
    static_level_i  = '0;
    now_i           = '0;
    act_bank        = 1'b0;
    for (i = 0; i < NUM_QUEUES; i++) begin
      q_head[i] = 0;
      q_fill[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table.
    foreach (dir_rows[r]) begin
      for (rep = 0; rep < int'(dir_rows[r].reps); rep++) begin
        offer_item(dir_rows[r].cmd, dir_rows[r].tag + 8'(rep), dir_rows[r].dyn,
                   dir_rows[r].stat, dir_rows[r].now + 32'(rep),
                   dir_rows[r].typed, dir_rows[r].want);
        pause_sender(gap_len());
      end
    end

    // Random phases: add-heavy phases fill FIFOs up to overflow, get-heavy ones
    // drain them and force bank swaps. Time mostly creeps forward, with rare jumps.
    clock_now = $urandom;
    phase_left = 0;
    add_pct = 50;
    quiet = 1'b0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(16, 64);
        case ($urandom_range(0, 2))
          0:       add_pct = 85;
          1:       add_pct = 50;
          default: add_pct = 15;
        endcase
        quiet = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      if (i == HOLD_AT_ITEM) hold_request = 1'b1;

      cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_GET;
      case ($urandom_range(0, 7))
        0:       dyn = 5'($urandom);
        1, 2:    dyn = DYN_EXPIRED;
        default: dyn = 5'($urandom_range(0, NUM_LEVELS - 1));
      endcase
      stat = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, NUM_LEVELS));
      if ($urandom_range(0, 63) == 0) clock_now = $urandom;
      else clock_now = clock_now + 32'($urandom_range(0, 50));

      offer_item(cmd, 8'($urandom), dyn, stat, clock_now, 1'b0, FROM_MODEL);
      pause_sender(quiet ? 0 : gap_len());
    end
    pause_sender(1);

    // Wait out every expected result, then DRAIN_CYCLES more for strays.
    while (expect_wr != expect_rd) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
